>>> hdl/rmem_pkg.sv
package rmem_pkg;

   localparam int MAX_COLS    = 1024;
   localparam int MAX_ROWS    = 4096;
   localparam int COL_W       = $clog2(MAX_COLS);
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int NUM_COLS_W  = 11;
   localparam int NUM_ROWS_W  = 13;
   localparam int WORD_W      = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int MAX_RESULTS = 3;
   localparam int RSP_DATA_W  = ((ROW_W + COL_W + WORD_W + 7) / 8) * 8;
   localparam int RSP_USER_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NUM_ROWS     = 2'd0,
      REG_NUM_COLS     = 2'd1,
      REG_BORDER_VALUE = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic              missing;
      logic [WORD_W-1:0] value;
   } cell_type;

   typedef struct packed {
      cell_type top;
      cell_type mid;
   } line_word_type;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [WORD_W-1:0] value;
      logic              missing;
      logic              is_edge;
      logic              last;
   } result_type;

   typedef struct packed {
      logic [1:0]                         count;
      result_type [MAX_RESULTS-1:0]       slot;
   } result_set_type;

endpackage

>>> hdl/rmem_line_buf.sv
module rmem_line_buf (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [rmem_pkg::COL_W-1:0]      rd_addr,
   input  logic                            wr_en,
   input  logic [rmem_pkg::COL_W-1:0]      wr_addr,
   input  rmem_pkg::line_word_type         wr_data,
   output rmem_pkg::line_word_type         rd_data
);

   rmem_pkg::line_word_type line_mem [rmem_pkg::MAX_COLS];
   rmem_pkg::line_word_type rd_ff;
   rmem_pkg::line_word_type byp_data_ff;
   logic                    byp_ff;
   logic                    byp_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff       <= line_mem[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   // same column written and read at one edge (single-column map)
   always_comb begin
      byp_in = byp_ff;
      if (rd_en) begin
         byp_in = wr_en && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;

endmodule

>>> hdl/rmem_edge_eval.sv
module rmem_edge_eval (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              win_en,
   input  rmem_pkg::cell_type                inc,
   input  rmem_pkg::cell_type                top,
   input  rmem_pkg::cell_type                mid,
   input  logic [rmem_pkg::ROW_W-1:0]        row,
   input  logic [rmem_pkg::COL_W-1:0]        col,
   input  logic [rmem_pkg::ROW_W-1:0]        nr_m1,
   input  logic [rmem_pkg::COL_W-1:0]        nc_m1,
   input  logic [rmem_pkg::WORD_W-1:0]       border,
   output rmem_pkg::result_set_type          set
);

   rmem_pkg::cell_type   win_ff [6];
   rmem_pkg::cell_type   win_in [6];
   rmem_pkg::result_type res0;
   rmem_pkg::result_type res1;
   rmem_pkg::result_type res2;
   logic [rmem_pkg::ROW_W-1:0] prev_row;
   logic [rmem_pkg::COL_W-1:0] prev_col;
   logic                       en0;
   logic                       en1;
   logic                       en2;
   logic                       nbr_miss;
   logic                       is_edge0;

   function automatic rmem_pkg::result_type make_result(
      input logic [rmem_pkg::ROW_W-1:0]  r,
      input logic [rmem_pkg::COL_W-1:0]  c,
      input rmem_pkg::cell_type          src,
      input logic                        brd,
      input logic [rmem_pkg::WORD_W-1:0] bval
   );
      rmem_pkg::result_type res;
      res.row  = r;
      res.col  = c;
      res.last = 1'b0;
      if (src.missing) begin
         res.value   = '0;
         res.missing = 1'b1;
         res.is_edge = 1'b0;
      end else if (brd) begin
         res.value   = bval;
         res.missing = 1'b0;
         res.is_edge = 1'b1;
      end else begin
         res.value   = src.value;
         res.missing = 1'b0;
         res.is_edge = 1'b0;
      end
      return res;
   endfunction

   always_comb begin
      prev_row = row - 1'b1;
      prev_col = col - 1'b1;
      en0      = (row != '0) && (col != '0);
      en1      = (row != '0) && (col == nc_m1);
      en2      = (row == nr_m1);
      nbr_miss = win_ff[0].missing || win_ff[2].missing || win_ff[3].missing ||
                 win_ff[4].missing || win_ff[5].missing || top.missing ||
                 mid.missing || inc.missing;
      is_edge0 = (prev_row == '0) || (prev_col == '0) || (prev_col == nc_m1) ||
                 (prev_row == nr_m1) || nbr_miss;
      res0 = make_result(prev_row, prev_col, win_ff[1], is_edge0, border);
      res1 = make_result(prev_row, col, mid, 1'b1, border);
      res2 = make_result(row, col, inc, 1'b1, border);

      set.count   = {1'b0, en0} + {1'b0, en1} + {1'b0, en2};
      set.slot[0] = en0 ? res0 : (en1 ? res1 : res2);
      set.slot[1] = (en0 && en1) ? res1 : res2;
      set.slot[2] = res2;
      set.slot[0].last = (set.count == 2'd1);
      set.slot[1].last = (set.count == 2'd2);
      set.slot[2].last = (set.count == 2'd3);
   end

   always_comb begin
      win_in[3] = win_ff[0];
      win_in[4] = win_ff[1];
      win_in[5] = win_ff[2];
      win_in[0] = top;
      win_in[1] = mid;
      win_in[2] = inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (win_en) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

endmodule

>>> hdl/rmem_result_queue.sv
module rmem_result_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  rmem_pkg::result_set_type            set,
   output logic                                can_load,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // row, col, value, zero pad
   output logic [rmem_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // missing, is_edge
   output logic [rmem_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast
);

   rmem_pkg::result_type slot_ff [rmem_pkg::MAX_RESULTS];
   rmem_pkg::result_type slot_in [rmem_pkg::MAX_RESULTS];
   logic [1:0]           cnt_ff;
   logic [1:0]           cnt_in;
   logic                 pop;

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign can_load   = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready);

   always_comb begin
      cnt_in = cnt_ff;
      for (int i = 0; i < rmem_pkg::MAX_RESULTS; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (load) begin
         cnt_in = set.count;
         for (int i = 0; i < rmem_pkg::MAX_RESULTS; i++) begin
            slot_in[i] = set.slot[i];
         end
      end else if (pop) begin
         cnt_in = cnt_ff - 1'b1;
         for (int i = 0; i < rmem_pkg::MAX_RESULTS - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < rmem_pkg::MAX_RESULTS; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   assign rsp_tdata = {{(rmem_pkg::RSP_DATA_W - rmem_pkg::ROW_W - rmem_pkg::COL_W -
                         rmem_pkg::WORD_W){1'b0}},
                       slot_ff[0].value, slot_ff[0].col, slot_ff[0].row};
   assign rsp_tuser = {slot_ff[0].is_edge, slot_ff[0].missing};
   assign rsp_tlast = slot_ff[0].last;

`ifndef NO_ASSERTIONS
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("result word changed while stalled");
   a_last_head: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (slot_ff[0].last == (cnt_ff == 2'd1)))
      else $error("last flag does not match queue fill");
   a_load_room: assert property (@(posedge clock) disable iff (reset)
      load |-> ((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop)))
      else $error("result set loaded over pending results");
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load |=> (cnt_ff == $past(set.count)))
      else $error("queue fill differs from loaded count");
`endif

endmodule

>>> hdl/raster_mask_edge_marker_core.sv
// Streaming 3x3 edge marker for a raster mask. Cells enter in row-major order, one word
// per cycle; each word makes zero to three result words, and the result for cell
// (r-1, c-1) leaves after cell (r, c) has entered, so a map is fully flushed by its own
// last cell. The input register stage takes one cell per cycle while the previous
// cell's results fit in the three-entry result queue; the queue sends one word per
// cycle while rsp_tready is high, so a cell ending a row (two results) or on the last
// row (up to three) holds the input longer. Results are registered in the queue.
// Neighbor rows come from a single 1024-deep line memory read once per cell. Line
// memory entries are not cleared at reset; stale entries reach only border results,
// whose value does not depend on them. Writing num_rows or num_cols restarts the map
// at row 0, column 0; write registers only while no results are pending.
module raster_mask_edge_marker_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // cell_value
   input  logic [rmem_pkg::WORD_W-1:0]            req_tdata,
   // cell_missing
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // out_row, out_col, out_value, zero pad
   output logic [rmem_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // out_missing, out_is_edge
   output logic [rmem_pkg::RSP_USER_W-1:0]        rsp_tuser,
   output logic                                   rsp_tlast,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rmem_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rmem_pkg::WORD_W-1:0]            csr_data
);

   logic [rmem_pkg::ROW_W-1:0]  nr_m1_ff;
   logic [rmem_pkg::ROW_W-1:0]  nr_m1_in;
   logic [rmem_pkg::COL_W-1:0]  nc_m1_ff;
   logic [rmem_pkg::COL_W-1:0]  nc_m1_in;
   logic [rmem_pkg::WORD_W-1:0] border_ff;
   logic [rmem_pkg::WORD_W-1:0] border_in;
   logic [rmem_pkg::ROW_W-1:0]  row_ff;
   logic [rmem_pkg::ROW_W-1:0]  row_in;
   logic [rmem_pkg::COL_W-1:0]  col_ff;
   logic [rmem_pkg::COL_W-1:0]  col_in;
   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   rmem_pkg::cell_type          s1_cell_ff;
   logic [rmem_pkg::ROW_W-1:0]  s1_row_ff;
   logic [rmem_pkg::COL_W-1:0]  s1_col_ff;
   logic                        csr_wr;
   logic                        pos_clr;
   logic                        req_accept;
   logic                        s1_adv;
   logic                        load;
   logic                        can_load;
   rmem_pkg::line_word_type     line_rd;
   rmem_pkg::line_word_type     line_wr;
   rmem_pkg::result_set_type    set;

   function automatic logic [rmem_pkg::ROW_W-1:0] rows_m1(
      input logic [rmem_pkg::NUM_ROWS_W-1:0] v
   );
      logic [rmem_pkg::ROW_W-1:0] res;
      if (v == '0) begin
         res = '0;
      end else if (v > rmem_pkg::NUM_ROWS_W'(rmem_pkg::MAX_ROWS)) begin
         res = rmem_pkg::ROW_W'(rmem_pkg::MAX_ROWS - 1);
      end else begin
         res = rmem_pkg::ROW_W'(v - 1'b1);
      end
      return res;
   endfunction

   function automatic logic [rmem_pkg::COL_W-1:0] cols_m1(
      input logic [rmem_pkg::NUM_COLS_W-1:0] v
   );
      logic [rmem_pkg::COL_W-1:0] res;
      if (v == '0) begin
         res = '0;
      end else if (v > rmem_pkg::NUM_COLS_W'(rmem_pkg::MAX_COLS)) begin
         res = rmem_pkg::COL_W'(rmem_pkg::MAX_COLS - 1);
      end else begin
         res = rmem_pkg::COL_W'(v - 1'b1);
      end
      return res;
   endfunction

   assign csr_ready  = 1'b1;
   assign csr_wr     = csr_valid && csr_ready;
   assign req_accept = req_tvalid && req_tready;
   assign s1_adv     = s1_valid_ff && ((set.count == 2'd0) || can_load);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign load       = s1_adv && (set.count != 2'd0);

   always_comb begin
      nr_m1_in  = nr_m1_ff;
      nc_m1_in  = nc_m1_ff;
      border_in = border_ff;
      pos_clr   = 1'b0;
      if (csr_wr) begin
         case (csr_index)
            rmem_pkg::REG_NUM_ROWS: begin
               nr_m1_in = rows_m1(csr_data[rmem_pkg::NUM_ROWS_W-1:0]);
               pos_clr  = 1'b1;
            end
            rmem_pkg::REG_NUM_COLS: begin
               nc_m1_in = cols_m1(csr_data[rmem_pkg::NUM_COLS_W-1:0]);
               pos_clr  = 1'b1;
            end
            rmem_pkg::REG_BORDER_VALUE: begin
               border_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (pos_clr) begin
         row_in = '0;
         col_in = '0;
      end else if (req_accept) begin
         if (col_ff == nc_m1_ff) begin
            col_in = '0;
            row_in = (row_ff == nr_m1_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nr_m1_ff    <= '0;
         nc_m1_ff    <= '0;
         border_ff   <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         nr_m1_ff    <= nr_m1_in;
         nc_m1_ff    <= nc_m1_in;
         border_ff   <= border_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cell_ff.value   <= req_tdata;
         s1_cell_ff.missing <= req_tuser;
         s1_row_ff          <= row_ff;
         s1_col_ff          <= col_ff;
      end
   end

   // older row takes the previous row, previous row takes the new cell
   assign line_wr.top = line_rd.mid;
   assign line_wr.mid = s1_cell_ff;

   rmem_line_buf u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr),
      .rd_data (line_rd)
   );

   rmem_edge_eval u_edge_eval (
      .clock  (clock),
      .reset  (reset),
      .win_en (s1_adv),
      .inc    (s1_cell_ff),
      .top    (line_rd.top),
      .mid    (line_rd.mid),
      .row    (s1_row_ff),
      .col    (s1_col_ff),
      .nr_m1  (nr_m1_ff),
      .nc_m1  (nc_m1_ff),
      .border (border_ff),
      .set    (set)
   );

   rmem_result_queue u_result_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .set        (set),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   a_pos_bounds: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= nc_m1_ff) && (row_ff <= nr_m1_ff))
      else $error("raster position beyond map size");
   a_stage_pos_bounds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !$past(csr_wr) |-> (s1_col_ff <= nc_m1_ff) && (s1_row_ff <= nr_m1_ff))
      else $error("held cell position beyond map size");
`endif

endmodule
